@@ hw/rtl/cvsp_pkg.sv @@
// cvsp_pkg: shared types and constants for the cascade varint stream parser.
// Holds the parse phase enum, the queue entry record and queue status.
// No dependencies.
`default_nettype none

package cvsp_pkg;

	// parse phases, also used as the field kind code
	typedef enum logic [3:0] {
		PH_STAGES = 4'd0,
		PH_WIDTH  = 4'd1,
		PH_HEIGHT = 4'd2,
		PH_FCOUNT = 4'd3,
		PH_THRESH = 4'd4,
		PH_PCOUNT = 4'd5,
		PH_COORD  = 4'd6,
		PH_ALPHA  = 4'd7,
		PH_DONE   = 4'd8
	} phase_t;

	localparam int unsigned PT_BITS     = 4;
	localparam int unsigned IDX_BITS    = 16;
	localparam int unsigned COORD_BITS  = 3;
	localparam int unsigned VAL_BITS    = 32;
	localparam logic [COORD_BITS-1:0] COORD_PER_POINT = 3'd6;
	localparam logic [6:0] VARINT_MASK = 7'h7f;

	// queue depth between front and back
	localparam int unsigned QDEPTH   = 2;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

	// one finished field as produced by the front
	typedef struct packed {
		phase_t                kind;
		logic [VAL_BITS-1:0]   value;
		logic [COORD_BITS-1:0] coord;
		logic [IDX_BITS-1:0]   sidx;
		logic [IDX_BITS-1:0]   fidx;
		logic [PT_BITS-1:0]    pidx;
		logic                  asel;
		logic                  over;
		logic                  clip;
		logic                  last;
	} field_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

@@ hw/rtl/cascade_varint_stream_parser_core.sv @@
// cascade_varint_stream_parser_core: top level of the cascade image parser.
// Connects front (byte assembly, sequencing), queue and back (output).
// Depends on cvsp_pkg, cvsp_front, cvsp_queue, cvsp_back.
//
//  channel  dir  beat content
//  s_axis   in   tdata = data_byte[7:0], tuser = start_req
//  m_axis   out  tdata = field_value, stage_index, feature_index, point_index
//                tuser = field_kind, coord_select, alpha_select, overlong,
//                        points_clipped; tlast = last
//
// One input byte per cycle while s_axis_tready is high. A finished field is
// registered first into the two-entry queue, then into the output register.
// Reset is asynchronous; no clearing pass, the block accepts at once.
// s_axis_tready drops only while the queue holds two records, which happens
// when m_axis stalls; bytes that finish no field still need queue room.
`default_nettype none

module cascade_varint_stream_parser_core
	import cvsp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 8,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // data_byte
	input  wire logic         s_axis_tuser,   // start_req
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,   // field_value, stage_index, feature_index, point_index
	output logic [9:0]        m_axis_tuser,   // field_kind, coord_select, alpha_select, overlong, points_clipped
	output logic              m_axis_tlast
);

	logic    accept;
	logic    push;
	logic    pop;
	field_t  front_entry;
	field_t  q_entry;
	qstat_t  q_stat;

	// input handshake
	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	cvsp_front #(
		.MAX_POINTS (MAX_POINTS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_axis_tdata),
		.start_req (s_axis_tuser),
		.push      (push),
		.entry     (front_entry)
	);

	cvsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (front_entry),
		.pop      (pop),
		.rd_entry (q_entry),
		.stat     (q_stat)
	);

	cvsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_entry       (q_entry),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a record is never written into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("push into full queue");

	// the image ends only after height, a threshold or an alpha
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(m_axis_tuser[3:0] == PH_HEIGHT || m_axis_tuser[3:0] == PH_THRESH ||
		 m_axis_tuser[3:0] == PH_ALPHA))
		else $error("last flag on unexpected field kind");

	// coordinate select stays within the six coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[3:0] == PH_COORD) |-> (m_axis_tuser[6:4] < 3'd6))
		else $error("coordinate select out of range");

	// float fields never carry the overlong flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[8]) |->
		(m_axis_tuser[3:0] != PH_THRESH && m_axis_tuser[3:0] != PH_ALPHA))
		else $error("overlong flag on float field");

endmodule

`default_nettype wire

@@ hw/rtl/cvsp_front.sv @@
// cvsp_front: byte assembly and field sequencing of the cascade image.
// Builds varints and floats, tracks stage/feature/point position, emits one
// field record per finished field. Depends on cvsp_pkg.
`default_nettype none

module cvsp_front
	import cvsp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 8,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   data_byte,
	input  wire logic         start_req,
	output logic              push,
	output field_t            entry
);

	localparam logic [32:0] CNT_MAX33 = (33'd1 << COUNT_BITS) - 33'd1;
	localparam logic [PT_BITS-1:0] MAXP = PT_BITS'(MAX_POINTS);

	phase_t                  phase_q, phase_n, cur_phase;
	logic [31:0]             acc_q, acc_n, cur_acc;
	logic [2:0]              bcnt_q, bcnt_n, cur_bcnt;
	logic [COUNT_BITS-1:0]   stages_tot_q, stages_tot_n, cur_stages_tot;
	logic [COUNT_BITS-1:0]   feat_tot_q, feat_tot_n, cur_feat_tot;
	logic [PT_BITS-1:0]      pts_tot_q, pts_tot_n, cur_pts_tot;
	logic [COUNT_BITS-1:0]   stage_cnt_q, stage_cnt_n, cur_stage_cnt;
	logic [COUNT_BITS-1:0]   feat_cnt_q, feat_cnt_n, cur_feat_cnt;
	logic [PT_BITS-1:0]      pt_cnt_q, pt_cnt_n, cur_pt_cnt;
	logic [COORD_BITS-1:0]   coord_cnt_q, coord_cnt_n, cur_coord_cnt;
	logic                    alpha_cnt_q, alpha_cnt_n, cur_alpha_cnt;

	logic                    restart;
	logic                    is_float;
	logic                    done;
	logic [4:0]              shamt;
	logic [31:0]             acc_sum;
	logic [COUNT_BITS-1:0]   sat_v;
	logic [COUNT_BITS-1:0]   stage_inc;
	logic [COUNT_BITS-1:0]   feat_inc;
	logic [COORD_BITS-1:0]   coord_inc;
	logic [PT_BITS-1:0]      pt_inc;
	logic [31:0]             sidx32;
	logic [31:0]             fidx32;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STAGES;
			acc_q        <= '0;
			bcnt_q       <= '0;
			stages_tot_q <= '0;
			feat_tot_q   <= '0;
			pts_tot_q    <= '0;
			stage_cnt_q  <= '0;
			feat_cnt_q   <= '0;
			pt_cnt_q     <= '0;
			coord_cnt_q  <= '0;
			alpha_cnt_q  <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			acc_q        <= acc_n;
			bcnt_q       <= bcnt_n;
			stages_tot_q <= stages_tot_n;
			feat_tot_q   <= feat_tot_n;
			pts_tot_q    <= pts_tot_n;
			stage_cnt_q  <= stage_cnt_n;
			feat_cnt_q   <= feat_cnt_n;
			pt_cnt_q     <= pt_cnt_n;
			coord_cnt_q  <= coord_cnt_n;
			alpha_cnt_q  <= alpha_cnt_n;
		end
	end

	// a start beat parses from the reset state
	always_comb begin
		restart        = accept && start_req;
		cur_phase      = restart ? PH_STAGES : phase_q;
		cur_acc        = restart ? '0 : acc_q;
		cur_bcnt       = restart ? '0 : bcnt_q;
		cur_stages_tot = restart ? '0 : stages_tot_q;
		cur_feat_tot   = restart ? '0 : feat_tot_q;
		cur_pts_tot    = restart ? '0 : pts_tot_q;
		cur_stage_cnt  = restart ? '0 : stage_cnt_q;
		cur_feat_cnt   = restart ? '0 : feat_cnt_q;
		cur_pt_cnt     = restart ? '0 : pt_cnt_q;
		cur_coord_cnt  = restart ? '0 : coord_cnt_q;
		cur_alpha_cnt  = restart ? 1'b0 : alpha_cnt_q;
	end

	// byte assembly: float bytes or 7-bit varint groups
	always_comb begin
		is_float = (cur_phase == PH_THRESH) || (cur_phase == PH_ALPHA);
		case (cur_bcnt)
			3'd0:    shamt = 5'd0;
			3'd1:    shamt = 5'd7;
			3'd2:    shamt = 5'd14;
			3'd3:    shamt = 5'd21;
			default: shamt = 5'd28;
		endcase
		if (is_float) begin
			acc_sum = cur_acc | (32'(data_byte) << {cur_bcnt[1:0], 3'b000});
			done    = (cur_bcnt >= 3'd3);
		end else begin
			acc_sum = cur_acc | (32'(data_byte[6:0] & VARINT_MASK) << shamt);
			done    = !data_byte[7] || (cur_bcnt >= 3'd4);
		end
		sat_v     = ({1'b0, acc_sum} > CNT_MAX33) ? CNT_MAX33[COUNT_BITS-1:0]
		                                          : acc_sum[COUNT_BITS-1:0];
		stage_inc = cur_stage_cnt + 1'b1;
		feat_inc  = cur_feat_cnt + 1'b1;
		coord_inc = cur_coord_cnt + 1'b1;
		pt_inc    = cur_pt_cnt + 1'b1;
		sidx32    = 32'(cur_stage_cnt);
		fidx32    = 32'(cur_feat_cnt);
	end

	// field sequencer
	always_comb begin
		phase_n      = cur_phase;
		acc_n        = cur_acc;
		bcnt_n       = cur_bcnt;
		stages_tot_n = cur_stages_tot;
		feat_tot_n   = cur_feat_tot;
		pts_tot_n    = cur_pts_tot;
		stage_cnt_n  = cur_stage_cnt;
		feat_cnt_n   = cur_feat_cnt;
		pt_cnt_n     = cur_pt_cnt;
		coord_cnt_n  = cur_coord_cnt;
		alpha_cnt_n  = cur_alpha_cnt;
		push         = 1'b0;
		entry        = '0;
		entry.kind   = cur_phase;
		entry.value  = acc_sum;
		if (accept && (cur_phase != PH_DONE)) begin
			if (!done) begin
				acc_n  = acc_sum;
				bcnt_n = cur_bcnt + 1'b1;
			end else begin
				acc_n      = '0;
				bcnt_n     = '0;
				push       = 1'b1;
				entry.over = !is_float && (cur_bcnt >= 3'd4) && data_byte[7];
				if (cur_phase >= PH_FCOUNT) begin
					entry.sidx = sidx32[IDX_BITS-1:0];
				end
				if (cur_phase >= PH_PCOUNT) begin
					entry.fidx = fidx32[IDX_BITS-1:0];
				end
				unique case (cur_phase)
					PH_STAGES: begin
						stages_tot_n = sat_v;
						phase_n      = PH_WIDTH;
					end
					PH_WIDTH: begin
						phase_n = PH_HEIGHT;
					end
					PH_HEIGHT: begin
						stage_cnt_n = '0;
						if (cur_stages_tot == '0) begin
							phase_n    = PH_DONE;
							entry.last = 1'b1;
						end else begin
							phase_n = PH_FCOUNT;
						end
					end
					PH_FCOUNT: begin
						feat_tot_n = sat_v;
						phase_n    = PH_THRESH;
					end
					PH_THRESH: begin
						feat_cnt_n = '0;
						if (cur_feat_tot == '0) begin
							stage_cnt_n = stage_inc;
							if ((stage_inc == '0) || (stage_inc >= cur_stages_tot)) begin
								phase_n    = PH_DONE;
								entry.last = 1'b1;
							end else begin
								phase_n = PH_FCOUNT;
							end
						end else begin
							phase_n = PH_PCOUNT;
						end
					end
					PH_PCOUNT: begin
						if (acc_sum > 32'(MAX_POINTS)) begin
							entry.value = 32'(MAXP);
							entry.clip  = 1'b1;
							pts_tot_n   = MAXP;
						end else begin
							pts_tot_n = acc_sum[PT_BITS-1:0];
						end
						pt_cnt_n    = '0;
						coord_cnt_n = '0;
						alpha_cnt_n = 1'b0;
						phase_n     = (pts_tot_n == '0) ? PH_ALPHA : PH_COORD;
					end
					PH_COORD: begin
						entry.coord = cur_coord_cnt;
						entry.pidx  = cur_pt_cnt;
						coord_cnt_n = coord_inc;
						if (coord_inc >= COORD_PER_POINT) begin
							coord_cnt_n = '0;
							pt_cnt_n    = pt_inc;
							if ((pt_inc == '0) || (pt_inc >= cur_pts_tot)) begin
								alpha_cnt_n = 1'b0;
								phase_n     = PH_ALPHA;
							end
						end
					end
					PH_ALPHA: begin
						entry.asel = cur_alpha_cnt;
						if (!cur_alpha_cnt) begin
							alpha_cnt_n = 1'b1;
						end else begin
							alpha_cnt_n = 1'b0;
							feat_cnt_n  = feat_inc;
							if ((feat_inc == '0) || (feat_inc >= cur_feat_tot)) begin
								stage_cnt_n = stage_inc;
								if ((stage_inc == '0) || (stage_inc >= cur_stages_tot)) begin
									phase_n    = PH_DONE;
									entry.last = 1'b1;
								end else begin
									feat_cnt_n = '0;
									phase_n    = PH_FCOUNT;
								end
							end else begin
								phase_n = PH_PCOUNT;
							end
						end
					end
					default: begin
						phase_n = cur_phase;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/cvsp_queue.sv @@
// cvsp_queue: short fifo of field records between front and back.
// Two entries, one write and one read port. Depends on cvsp_pkg.
`default_nettype none

module cvsp_queue
	import cvsp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire field_t wr_entry,
	input  wire logic   pop,
	output field_t      rd_entry,
	output qstat_t      stat
);

	field_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_entry   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ hw/rtl/cvsp_back.sv @@
// cvsp_back: output stage of the parser; zigzag-decodes coordinates and
// holds the result beat in an output register. Depends on cvsp_pkg.
`default_nettype none

module cvsp_back
	import cvsp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire field_t       q_entry,
	input  wire qstat_t       q_stat,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,  // field_value, stage_index, feature_index, point_index, pad
	output logic [9:0]        m_axis_tuser,  // field_kind, coord_select, alpha_select, overlong, points_clipped
	output logic              m_axis_tlast
);

	field_t       out_q;
	field_t       dec_entry;
	logic [31:0]  dec_value;

	// pull from the queue when the output register is free or draining
	assign pop = !q_stat.empty && (!m_axis_tvalid || m_axis_tready);

	// zigzag decode for coordinates
	always_comb begin
		if (q_entry.kind == PH_COORD) begin
			dec_value = (q_entry.value >> 1) ^ (32'd0 - 32'(q_entry.value[0]));
		end else begin
			dec_value = q_entry.value;
		end
	end

	// record with the decoded value
	always_comb begin
		dec_entry       = q_entry;
		dec_entry.value = dec_value;
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (!m_axis_tvalid || m_axis_tready) begin
			m_axis_tvalid <= !q_stat.empty;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= dec_entry;
		end
	end

	assign m_axis_tdata = {4'd0, out_q.pidx, out_q.fidx, out_q.sidx, out_q.value};
	assign m_axis_tuser = {out_q.clip, out_q.over, out_q.asel, out_q.coord, 4'(out_q.kind)};
	assign m_axis_tlast = out_q.last;

endmodule

`default_nettype wire

@@ verif/cvsp_field_checker.sv @@
// cvsp_field_checker: watches both stream channels of the cascade parser core,
// predicts each field beat from the accepted input bytes and compares it.
// Depends on cvsp_pkg for the phase enum and the field record.

module cvsp_field_checker
	import cvsp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 8,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // start_req
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,   // field_value, stage_index, feature_index, point_index
	input  logic [9:0]  m_axis_tuser,   // field_kind, coord_select, alpha_select, overlong, points_clipped
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          fields_due
);

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	// mirror of the parser state
	phase_t                phase;
	logic [31:0]           acc;
	logic [2:0]            nbytes;
	logic [COUNT_BITS-1:0] stages_total;
	logic [COUNT_BITS-1:0] features_total;
	logic [COUNT_BITS-1:0] stage_no;
	logic [COUNT_BITS-1:0] feature_no;
	logic [3:0]            points_total;
	logic [3:0]            point_no;
	logic [2:0]            coord_no;
	logic                  alpha_no;

	// predicted fields not yet seen on the output
	field_t fields_q[$];
	int     beats_out;

	initial mismatches = 0;

	function automatic void clear_parse();
		phase          = PH_STAGES;
		acc            = '0;
		nbytes         = '0;
		stages_total   = '0;
		features_total = '0;
		stage_no       = '0;
		feature_no     = '0;
		points_total   = '0;
		point_no       = '0;
		coord_no       = '0;
		alpha_no       = 1'b0;
	endfunction

	// counts above the index range stick at all ones for sequencing
	function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [31:0] v);
		return (64'(v) > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(v);
	endfunction

	// step past a finished stage, returns 1 when the image is complete
	function automatic bit advance_stage();
		stage_no = stage_no + 1'b1;
		if (stage_no == '0 || stage_no >= stages_total) begin
			phase = PH_DONE;
			return 1'b1;
		end
		feature_no = '0;
		phase = PH_FCOUNT;
		return 1'b0;
	endfunction

	// feed one byte, returns 1 with the finished field when one completes
	function automatic bit decode_octet(input logic [7:0] b, input logic restart,
			output field_t f);
		phase_t      kind;
		logic [31:0] val;
		logic        fin;
		f = '0;
		if (restart)
			clear_parse();
		if (phase > PH_ALPHA)
			return 1'b0;
		kind = phase;
		if (kind == PH_THRESH || kind == PH_ALPHA) begin
			// raw float, four bytes little endian
			acc |= 32'(b) << (8 * nbytes[1:0]);
			fin = (nbytes >= 3'd3);
		end else begin
			// varint group, the fifth byte always ends it
			acc |= 32'(b[6:0]) << (7 * int'(nbytes));
			fin = !b[7] || nbytes >= 3'd4;
			f.over = b[7] && nbytes >= 3'd4;
		end
		if (!fin) begin
			nbytes++;
			return 1'b0;
		end
		val = acc;
		acc = '0;
		nbytes = '0;
		f.kind = kind;
		if (kind >= PH_FCOUNT)
			f.sidx = stage_no;
		if (kind >= PH_PCOUNT)
			f.fidx = feature_no;
		case (kind)
			PH_STAGES: begin
				stages_total = clamp_count(val);
				phase = PH_WIDTH;
			end
			PH_WIDTH: phase = PH_HEIGHT;
			PH_HEIGHT: begin
				stage_no = '0;
				if (stages_total == '0) begin
					phase = PH_DONE;
					f.last = 1'b1;
				end else begin
					phase = PH_FCOUNT;
				end
			end
			PH_FCOUNT: begin
				features_total = clamp_count(val);
				phase = PH_THRESH;
			end
			PH_THRESH: begin
				feature_no = '0;
				if (features_total == '0)
					f.last = advance_stage();
				else
					phase = PH_PCOUNT;
			end
			PH_PCOUNT: begin
				if (val > MAX_POINTS) begin
					val = MAX_POINTS;
					f.clip = 1'b1;
				end
				points_total = val[3:0];
				point_no = '0;
				coord_no = '0;
				alpha_no = 1'b0;
				phase = (points_total == '0) ? PH_ALPHA : PH_COORD;
			end
			PH_COORD: begin
				// undo the zigzag mapping
				val = (val >> 1) ^ {32{val[0]}};
				f.coord = coord_no;
				f.pidx = point_no;
				coord_no++;
				if (coord_no >= COORD_PER_POINT) begin
					coord_no = '0;
					point_no++;
					if (point_no == '0 || point_no >= points_total) begin
						alpha_no = 1'b0;
						phase = PH_ALPHA;
					end
				end
			end
			default: begin
				f.asel = alpha_no;
				if (!alpha_no) begin
					alpha_no = 1'b1;
				end else begin
					alpha_no = 1'b0;
					feature_no = feature_no + 1'b1;
					if (feature_no == '0 || feature_no >= features_total)
						f.last = advance_stage();
					else
						phase = PH_PCOUNT;
				end
			end
		endcase
		f.value = val;
		return 1'b1;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("field beat %0d: %s is %h, predicted %h", beats_out, what, got, want);
		mismatches++;
	endtask

	task automatic compare_field(input field_t got, input field_t want, input logic [3:0] pad);
		if (got.kind !== want.kind)
			report("field_kind", got.kind, want.kind);
		if (got.value !== want.value)
			report("field_value", got.value, want.value);
		if (got.coord !== want.coord)
			report("coord_select", got.coord, want.coord);
		if (got.sidx !== want.sidx)
			report("stage_index", got.sidx, want.sidx);
		if (got.fidx !== want.fidx)
			report("feature_index", got.fidx, want.fidx);
		if (got.pidx !== want.pidx)
			report("point_index", got.pidx, want.pidx);
		if (got.asel !== want.asel)
			report("alpha_select", got.asel, want.asel);
		if (got.over !== want.over)
			report("overlong", got.over, want.over);
		if (got.clip !== want.clip)
			report("points_clipped", got.clip, want.clip);
		if (got.last !== want.last)
			report("last", got.last, want.last);
		if (pad !== 4'd0)
			report("tdata padding", pad, 4'd0);
	endtask

	// output beats checked first, then the accepted byte is predicted
	always @(posedge clk or negedge arst_n) begin : watch
		field_t got;
		field_t want;
		field_t next_field;
		if (!arst_n) begin
			clear_parse();
			fields_q.delete();
			beats_out = 0;
			fields_due <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata[31:0];
				got.sidx  = m_axis_tdata[47:32];
				got.fidx  = m_axis_tdata[63:48];
				got.pidx  = m_axis_tdata[67:64];
				got.kind  = phase_t'(m_axis_tuser[3:0]);
				got.coord = m_axis_tuser[6:4];
				got.asel  = m_axis_tuser[7];
				got.over  = m_axis_tuser[8];
				got.clip  = m_axis_tuser[9];
				got.last  = m_axis_tlast;
				if (fields_q.size() == 0) begin
					report("beat with no field due, value", got.value, '0);
				end else begin
					want = fields_q.pop_front();
					compare_field(got, want, m_axis_tdata[71:68]);
				end
				beats_out++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (decode_octet(s_axis_tdata, s_axis_tuser, next_field))
					fields_q.push_back(next_field);
			end
			fields_due <= fields_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
// tb: byte stimulus for the cascade parser core with random stalls on both sides.
// Instantiates cascade_varint_stream_parser_core and cvsp_field_checker.
// Gives the verdict from the checker's mismatch count and due count.

module tb;

	localparam int unsigned MAX_PTS = 8;
	localparam int unsigned CNT_BITS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_BYTES = 550;
	localparam int SQUEEZE_AT = 150;
	localparam int SQUEEZE_LEN = 300;
	localparam int DRAIN_CYCLES = 8;

	// directed opening, each entry is {start_req, data_byte}
	localparam logic [8:0] OPENING [25] = '{
		// zero stages, padded width, height of five groups; last on height
		9'h100, 9'h080, 9'h000, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h07f,
		// bytes after the end are dropped
		9'h055, 9'h0aa,
		// overlong stage count, saturates the stage total
		9'h181, 9'h080, 9'h080, 9'h080, 9'h0ff, 9'h001, 9'h002,
		// restart mid image: one stage with no features, last on threshold
		9'h101, 9'h001, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // data_byte
	logic        s_axis_tuser;   // start_req
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // field_value, stage_index, feature_index, point_index
	logic [9:0]  m_axis_tuser;   // field_kind, coord_select, alpha_select, overlong, points_clipped
	logic        m_axis_tlast;

	int mismatches;
	int fields_due;

	logic [8:0] image_bytes_q[$];
	bit         start_next;
	int         room;
	int         parse_bytes;
	int         beats_in;
	bit         squeezed;
	int         cycle_count;

	cascade_varint_stream_parser_core #(
		.MAX_POINTS(MAX_PTS),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	cvsp_field_checker #(
		.MAX_POINTS(MAX_PTS),
		.COUNT_BITS(CNT_BITS)
	) field_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.fields_due    (fields_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// mostly short idles, a few long ones
	function automatic int idle_len();
		return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// value of random magnitude
	function automatic logic [31:0] rand_mag();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// a count too large to sequence through, some beyond the index range
	function automatic logic [31:0] big_count();
		return $urandom_range(0, 1) ? $urandom : $urandom_range(4, 70000);
	endfunction

	// zigzag code of a signed coordinate, extremes included
	function automatic logic [31:0] pick_coord_code();
		logic [31:0] c;
		case ($urandom_range(0, 9))
			0: c = 32'h7fff_ffff;
			1: c = 32'h8000_0000;
			2, 3: c = $urandom;
			default: c = 32'(int'($urandom_range(0, 128)) - 64);
		endcase
		return (c << 1) ^ {32{c[31]}};
	endfunction

	function automatic void push_octet(input logic [7:0] b);
		if (room > 0) begin
			image_bytes_q.push_back({start_next, b});
			start_next = 1'b0;
			room--;
			parse_bytes++;
		end
	endfunction

	// varint, minimal, padded with empty groups, or five groups all continued
	function automatic void push_varint(input logic [31:0] v);
		logic [7:0]  grp[$];
		logic [31:0] rest;
		int          style;
		int          pad;
		rest = v;
		style = $urandom_range(0, 99);
		if (style < 8) begin
			for (int i = 0; i < 4; i++) begin
				grp.push_back({1'b1, rest[6:0]});
				rest = rest >> 7;
			end
			grp.push_back({1'b1, 3'($urandom), rest[3:0]});
		end else begin
			do begin
				grp.push_back({1'(rest > 32'd127), rest[6:0]});
				rest = rest >> 7;
			end while (rest != 0);
			if (style < 20 && grp.size() < 5) begin
				pad = $urandom_range(1, 5 - grp.size());
				grp[grp.size() - 1] = grp[grp.size() - 1] | 8'h80;
				repeat (pad - 1) grp.push_back(8'h80);
				grp.push_back(8'h00);
			end
		end
		foreach (grp[i])
			push_octet(grp[i]);
	endfunction

	function automatic void push_float();
		repeat (4) push_octet(8'($urandom));
	endfunction

	// well formed image with random content, sometimes cut short
	function automatic void add_image();
		logic [31:0] n_st;
		logic [31:0] n_ft;
		logic [31:0] n_pt;
		int          st_cnt;
		int          ft_cnt;
		int          pt_cnt;
		int          r;
		start_next = 1'b1;
		room = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 40) : 32'h7fff_ffff;
		n_st = ($urandom_range(0, 99) < 6) ? big_count() : $urandom_range(0, 3);
		st_cnt = (n_st > 3) ? 1 : int'(n_st);
		push_varint(n_st);
		push_varint(rand_mag());
		push_varint(rand_mag());
		for (int s = 0; s < st_cnt; s++) begin
			n_ft = ($urandom_range(0, 99) < 6) ? big_count() : $urandom_range(0, 2);
			ft_cnt = (n_ft > 2) ? 1 : int'(n_ft);
			push_varint(n_ft);
			push_float();
			for (int f = 0; f < ft_cnt; f++) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					n_pt = $urandom_range(0, 1) ? $urandom : $urandom_range(MAX_PTS + 1, 40);
				else if (r < 25)
					n_pt = $urandom_range(4, MAX_PTS);
				else
					n_pt = $urandom_range(0, 3);
				pt_cnt = (n_pt > MAX_PTS) ? MAX_PTS : int'(n_pt);
				push_varint(n_pt);
				repeat (pt_cnt * 6) push_varint(pick_coord_code());
				push_float();
				push_float();
			end
			// a feature count too large to finish leaves the image open
			if (n_ft > 2)
				return;
		end
	endfunction

	// random bytes with an occasional restart inside
	function automatic void add_noise();
		int n;
		n = $urandom_range(2, 12);
		for (int k = 0; k < n; k++)
			image_bytes_q.push_back({1'(k == 0 || $urandom_range(0, 15) == 0), 8'($urandom)});
		parse_bytes += n;
	endfunction

	// sink: random stalls, calm stretches and one long hold-off
	initial begin : sink
		int hold;
		int span;
		bit calm;
		hold = 0;
		span = 0;
		calm = 1'b0;
		squeezed = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span = $urandom_range(50, 200);
				calm = ($urandom_range(0, 3) == 0);
			end
			span--;
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (!squeezed && beats_in >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				hold = SQUEEZE_LEN - 1;
				m_axis_tready <= 1'b0;
			end else if (calm || $urandom_range(0, 99) < 65) begin
				m_axis_tready <= 1'b1;
			end else begin
				hold = idle_len() - 1;
				m_axis_tready <= 1'b0;
			end
		end
	end

	// source: reset, build the byte stream, send it, then give the verdict
	initial begin : source
		int gap;
		int span;
		bit calm;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		beats_in = 0;
		span = 0;
		calm = 1'b0;

		foreach (OPENING[i])
			image_bytes_q.push_back(OPENING[i]);
		parse_bytes = 0;
		while (parse_bytes < TARGET_BYTES) begin
			if ($urandom_range(0, 99) < 8)
				add_noise();
			else
				add_image();
			// trailing bytes, ignored when the image was complete
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, 4)) image_bytes_q.push_back({1'b0, 8'($urandom)});
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (image_bytes_q[i]) begin
			if (span == 0) begin
				span = $urandom_range(20, 120);
				calm = ($urandom_range(0, 3) == 0);
			end
			span--;
			gap = (calm || $urandom_range(0, 99) < 70) ? 0 : idle_len();
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
			@(negedge clk);
			s_axis_tvalid <= 1'b1;
			{s_axis_tuser, s_axis_tdata} <= image_bytes_q[i];
			do @(posedge clk); while (!s_axis_tready);
			beats_in++;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// drain, then allow the pipeline depth for stray beats
		while (fields_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && fields_due == 0 && !m_axis_tvalid)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ cascade_varint_stream_parser_core.f @@
hw/rtl/cvsp_pkg.sv
hw/rtl/cvsp_front.sv
hw/rtl/cvsp_queue.sv
hw/rtl/cvsp_back.sv
hw/rtl/cascade_varint_stream_parser_core.sv
verif/cvsp_field_checker.sv
verif/tb.sv
